// ===== hdl/cls_pkg.sv =====
// shared constants and types for the circular list key store
package cls_pkg;

	// node store geometry
	localparam int CAPACITY = 32;
	localparam int PTR_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 6;
	localparam int KEY_W    = 32;

	// operation codes of an input beat
	typedef enum logic [1:0] {
		OP_INS_FRONT = 2'd0,
		OP_INS_END   = 2'd1,
		OP_DELETE    = 2'd2,
		OP_DUMP      = 2'd3
	} op_t;

	// status codes of a result beat
	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_FULL    = 2'd1,
		STS_EMPTY   = 2'd2,
		STS_MISSING = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_DEL_NEXT,
		S_DEL_CHK,
		S_DMP_NEXT,
		S_DMP_EMIT,
		S_RESP
	} state_t;

endpackage

// ===== hdl/cls_ram.sv =====
// generic single-write, single-read ram with registered read data
module cls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/circular_list_key_store.sv =====
// circular list key store: node memories, free map and list sequencer
//
// Input channel (in_valid/in_ready) takes one beat of operation and key:
// insert at front, insert at end, delete first matching key, or dump list.
// Output channel (out_valid/out_ready) gives result beats of status,
// key_out, last_of_run and entry_count; every operation ends with a beat
// that has last_of_run set, a dump gives one beat per node front to back.
// One item is worked on at a time. A delete or a dump walks the linked
// nodes front to back, reading one node per cycle (a dump only while
// the receiver takes its beats) from the key and next-link memories,
// whose read data is registered.
// A new item is taken once the previous one has handed its final beat to
// the output register, so it may arrive while that beat still waits.
// When the receiver stalls, the output register holds its beat and the
// walk pauses on the current node.
// Reset empties the list at once (all nodes free, count zero); the node
// memories are not cleared, since only written nodes are ever visited.
module circular_list_key_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               operation,
	input  logic signed [31:0]       key,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic signed [31:0]       key_out,
	output logic                     last_of_run,
	output logic [5:0]               entry_count
);

	localparam int CAP   = cls_pkg::CAPACITY;
	localparam int PTR_W = cls_pkg::PTR_W;
	localparam int CNT_W = cls_pkg::CNT_W;
	localparam int KEY_W = cls_pkg::KEY_W;

	cls_pkg::state_t  state_q, state_d;
	cls_pkg::status_t res_status_q, res_status_d;
	cls_pkg::op_t     op_in;

	logic [KEY_W-1:0] key_q, key_d;
	logic [PTR_W-1:0] slot_q, slot_d;
	logic [PTR_W-1:0] prev_q, prev_d;
	logic [PTR_W-1:0] pres_q, pres_d;
	logic [PTR_W-1:0] last_q, last_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] size_q, size_d;
	logic [CAP-1:0]   free_q, free_d;
	logic             at_end_q, at_end_d;

	logic [PTR_W-1:0] free_slot;
	logic [PTR_W-1:0] rd_addr;
	logic [KEY_W-1:0] key_rd;
	logic [PTR_W-1:0] next_rd;
	logic             key_we;
	logic [PTR_W-1:0] key_waddr;
	logic             next_we;
	logic [PTR_W-1:0] next_waddr;
	logic [PTR_W-1:0] next_wdata;

	logic             out_free;
	logic             push;
	cls_pkg::status_t push_status;
	logic [KEY_W-1:0] push_key;
	logic             push_last;

	logic             out_valid_q;
	cls_pkg::status_t status_q;
	logic [KEY_W-1:0] key_out_q;
	logic             last_of_run_q;
	logic [CNT_W-1:0] entry_count_q;

	// node memories
	cls_ram #(.WIDTH(KEY_W), .DEPTH(CAP)) u_key_mem (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (key_waddr),
		.wr_data (key_d),
		.rd_addr (rd_addr),
		.rd_data (key_rd)
	);

	cls_ram #(.WIDTH(PTR_W), .DEPTH(CAP)) u_next_mem (
		.clk     (clk),
		.wr_en   (next_we),
		.wr_addr (next_waddr),
		.wr_data (next_wdata),
		.rd_addr (rd_addr),
		.rd_data (next_rd)
	);

	// lowest free node
	always_comb begin
		free_slot = '0;
		for (int i = CAP - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_slot = PTR_W'(i);
			end
		end
	end

	assign op_in    = cls_pkg::op_t'(operation);
	assign in_ready = (state_q == cls_pkg::S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// sequencer: next state, memory accesses and result beats
	always_comb begin
		state_d      = state_q;
		res_status_d = res_status_q;
		key_d        = key_q;
		slot_d       = slot_q;
		prev_d       = prev_q;
		pres_d       = pres_q;
		last_d       = last_q;
		cnt_d        = cnt_q;
		size_d       = size_q;
		free_d       = free_q;
		at_end_d     = at_end_q;
		rd_addr      = pres_q;
		key_we       = 1'b0;
		key_waddr    = free_slot;
		next_we      = 1'b0;
		next_waddr   = slot_q;
		next_wdata   = next_rd;
		push         = 1'b0;
		push_status  = res_status_q;
		push_key     = '0;
		push_last    = 1'b1;

		unique case (state_q)
			cls_pkg::S_IDLE: begin
				if (in_valid) begin
					key_d    = key;
					at_end_d = (op_in == cls_pkg::OP_INS_END);
					unique case (op_in)
						cls_pkg::OP_INS_FRONT, cls_pkg::OP_INS_END: begin
							if (size_q == CNT_W'(CAP)) begin
								res_status_d = cls_pkg::STS_FULL;
								state_d      = cls_pkg::S_RESP;
							end else begin
								// key goes straight into the new node
								key_we    = 1'b1;
								key_waddr = free_slot;
								slot_d    = free_slot;
								if (size_q == '0) begin
									next_we      = 1'b1;
									next_waddr   = free_slot;
									next_wdata   = free_slot;
									last_d       = free_slot;
									free_d       = free_q & ~(CAP'(1) << free_slot);
									size_d       = size_q + CNT_W'(1);
									res_status_d = cls_pkg::STS_OK;
									state_d      = cls_pkg::S_RESP;
								end else begin
									rd_addr = last_q;
									state_d = cls_pkg::S_INS_RD;
								end
							end
						end
						cls_pkg::OP_DELETE, cls_pkg::OP_DUMP: begin
							if (size_q == '0) begin
								res_status_d = cls_pkg::STS_EMPTY;
								state_d      = cls_pkg::S_RESP;
							end else begin
								rd_addr = last_q;
								prev_d  = last_q;
								cnt_d   = '0;
								state_d = (op_in == cls_pkg::OP_DELETE) ?
									cls_pkg::S_DEL_NEXT : cls_pkg::S_DMP_NEXT;
							end
						end
						default: ;
					endcase
				end
			end
			cls_pkg::S_INS_RD: begin
				// new node points at the old first node
				next_we    = 1'b1;
				next_waddr = slot_q;
				next_wdata = next_rd;
				state_d    = cls_pkg::S_INS_WR;
			end
			cls_pkg::S_INS_WR: begin
				// old last node points at the new node
				next_we      = 1'b1;
				next_waddr   = last_q;
				next_wdata   = slot_q;
				if (at_end_q) begin
					last_d = slot_q;
				end
				free_d       = free_q & ~(CAP'(1) << slot_q);
				size_d       = size_q + CNT_W'(1);
				res_status_d = cls_pkg::STS_OK;
				state_d      = cls_pkg::S_RESP;
			end
			cls_pkg::S_DEL_NEXT: begin
				pres_d  = next_rd;
				rd_addr = next_rd;
				state_d = cls_pkg::S_DEL_CHK;
			end
			cls_pkg::S_DEL_CHK: begin
				if (key_rd == key_q) begin
					// unlink the matching node
					if (size_q == CNT_W'(1)) begin
						last_d = '0;
					end else begin
						next_we    = 1'b1;
						next_waddr = prev_q;
						next_wdata = next_rd;
						if (pres_q == last_q) begin
							last_d = prev_q;
						end
					end
					free_d       = free_q | (CAP'(1) << pres_q);
					size_d       = size_q - CNT_W'(1);
					res_status_d = cls_pkg::STS_OK;
					state_d      = cls_pkg::S_RESP;
				end else if (cnt_q + CNT_W'(1) == size_q) begin
					res_status_d = cls_pkg::STS_MISSING;
					state_d      = cls_pkg::S_RESP;
				end else begin
					prev_d  = pres_q;
					pres_d  = next_rd;
					rd_addr = next_rd;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			cls_pkg::S_DMP_NEXT: begin
				pres_d  = next_rd;
				rd_addr = next_rd;
				cnt_d   = '0;
				state_d = cls_pkg::S_DMP_EMIT;
			end
			cls_pkg::S_DMP_EMIT: begin
				// one beat per node, walk holds while the output is full
				if (out_free) begin
					push        = 1'b1;
					push_status = cls_pkg::STS_OK;
					push_key    = key_rd;
					push_last   = (cnt_q + CNT_W'(1) == size_q);
					if (push_last) begin
						state_d = cls_pkg::S_IDLE;
					end else begin
						cnt_d   = cnt_q + CNT_W'(1);
						pres_d  = next_rd;
						rd_addr = next_rd;
					end
				end
			end
			cls_pkg::S_RESP: begin
				if (out_free) begin
					push        = 1'b1;
					push_status = res_status_q;
					push_key    = '0;
					push_last   = 1'b1;
					state_d     = cls_pkg::S_IDLE;
				end
			end
			default: state_d = cls_pkg::S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cls_pkg::S_IDLE;
			last_q  <= '0;
			size_q  <= '0;
			free_q  <= '1;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
			size_q  <= size_d;
			free_q  <= free_d;
			cnt_q   <= cnt_d;
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		key_q        <= key_d;
		slot_q       <= slot_d;
		prev_q       <= prev_d;
		pres_q       <= pres_d;
		at_end_q     <= at_end_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			status_q      <= push_status;
			key_out_q     <= push_key;
			last_of_run_q <= push_last;
			entry_count_q <= size_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign key_out     = key_out_q;
	assign last_of_run = last_of_run_q;
	assign entry_count = entry_count_q;

	// free map and count agree
	a_size_free: assert property (@(posedge clk) disable iff (!arst_n)
		32'(size_q) + 32'($countones(free_q)) == 32'(CAP))
		else $error("list size and free map disagree");

	// last node of a non-empty list is in use
	a_last_used: assert property (@(posedge clk) disable iff (!arst_n)
		(size_q != '0) |-> !free_q[last_q])
		else $error("last node marked free");

	// delete and dump walks never run past the list
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cls_pkg::S_DEL_CHK || state_q == cls_pkg::S_DMP_EMIT)
		|-> cnt_q < size_q)
		else $error("walk beyond list length");

	// error results are always single beats
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != cls_pkg::STS_OK) |-> last_of_run_q)
		else $error("error result not marked last");

	// a new beat is only loaded into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid_q || out_ready))
		else $error("result beat overwritten");

endmodule

// ===== tb/tb_top.sv =====
// testbench for the circular list key store: table-driven and random beats vs. a list predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = cls_pkg::CAPACITY;
	localparam int PTR_W    = cls_pkg::PTR_W;
	localparam int CNT_W    = cls_pkg::CNT_W;
	localparam int KEY_W    = cls_pkg::KEY_W;

	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 2 * CAPACITY + 8;
	localparam int MIXED_ITEMS = 35;

	// one result beat as the block should give it
	typedef struct {
		cls_pkg::status_t        st;
		logic signed [KEY_W-1:0] k;
		logic                    last;
		logic [CNT_W-1:0]        cnt;
	} beat_t;

	// one row of the directed table; typed rows carry their own single result
	typedef struct packed {
		cls_pkg::op_t     op;
		logic [KEY_W-1:0] k;
		logic             typed;
		cls_pkg::status_t st;
		logic [CNT_W-1:0] cnt;
	} step_t;

	localparam int N_DIRECTED = 25;
	localparam step_t DIRECTED [N_DIRECTED] = '{
		'{cls_pkg::OP_DUMP,      32'h0000_0000, 1'b1, cls_pkg::STS_EMPTY,   6'd0},
		'{cls_pkg::OP_DELETE,    32'h0000_0005, 1'b1, cls_pkg::STS_EMPTY,   6'd0},
		'{cls_pkg::OP_INS_FRONT, 32'h7fff_ffff, 1'b1, cls_pkg::STS_OK,      6'd1},
		'{cls_pkg::OP_INS_END,   32'h8000_0000, 1'b1, cls_pkg::STS_OK,      6'd2},
		'{cls_pkg::OP_INS_FRONT, 32'h0000_0000, 1'b1, cls_pkg::STS_OK,      6'd3},
		'{cls_pkg::OP_INS_END,   32'hffff_ffff, 1'b1, cls_pkg::STS_OK,      6'd4},
		'{cls_pkg::OP_INS_END,   32'h0000_0005, 1'b1, cls_pkg::STS_OK,      6'd5},
		'{cls_pkg::OP_INS_FRONT, 32'h0000_0005, 1'b1, cls_pkg::STS_OK,      6'd6},
		'{cls_pkg::OP_DUMP,      32'hdead_beef, 1'b0, cls_pkg::STS_OK,      6'd0},
		'{cls_pkg::OP_DELETE,    32'h0000_3039, 1'b1, cls_pkg::STS_MISSING, 6'd6},
		'{cls_pkg::OP_DELETE,    32'h0000_0005, 1'b1, cls_pkg::STS_OK,      6'd5},
		'{cls_pkg::OP_DUMP,      32'h0000_0000, 1'b0, cls_pkg::STS_OK,      6'd0},
		'{cls_pkg::OP_DELETE,    32'h0000_0005, 1'b1, cls_pkg::STS_OK,      6'd4},
		'{cls_pkg::OP_INS_END,   32'h0000_5a5a, 1'b1, cls_pkg::STS_OK,      6'd5},
		'{cls_pkg::OP_DUMP,      32'hffff_ffff, 1'b0, cls_pkg::STS_OK,      6'd0},
		'{cls_pkg::OP_DELETE,    32'h7fff_ffff, 1'b1, cls_pkg::STS_OK,      6'd4},
		'{cls_pkg::OP_DELETE,    32'h0000_0000, 1'b1, cls_pkg::STS_OK,      6'd3},
		'{cls_pkg::OP_DELETE,    32'h0000_5a5a, 1'b1, cls_pkg::STS_OK,      6'd2},
		'{cls_pkg::OP_DELETE,    32'h8000_0000, 1'b1, cls_pkg::STS_OK,      6'd1},
		'{cls_pkg::OP_DUMP,      32'h0000_0000, 1'b0, cls_pkg::STS_OK,      6'd0},
		'{cls_pkg::OP_DELETE,    32'hffff_ffff, 1'b1, cls_pkg::STS_OK,      6'd0},
		'{cls_pkg::OP_DUMP,      32'h0000_0000, 1'b1, cls_pkg::STS_EMPTY,   6'd0},
		'{cls_pkg::OP_DELETE,    32'h0000_0000, 1'b1, cls_pkg::STS_EMPTY,   6'd0},
		'{cls_pkg::OP_INS_END,   32'h1234_5678, 1'b1, cls_pkg::STS_OK,      6'd1},
		'{cls_pkg::OP_DUMP,      32'h0000_0000, 1'b0, cls_pkg::STS_OK,      6'd0}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [1:0]               operation = cls_pkg::OP_INS_FRONT;
	logic signed [KEY_W-1:0]  key = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [1:0]               status;
	logic signed [KEY_W-1:0]  key_out;
	logic                     last_of_run;
	logic [CNT_W-1:0]         entry_count;

	// predicted list: node keys, next links, free nodes, last node, size
	logic signed [KEY_W-1:0]  node_key [CAPACITY];
	logic [PTR_W-1:0]         node_next [CAPACITY];
	logic [CAPACITY-1:0]      vacant;
	logic [PTR_W-1:0]         tail;
	int                       held;

	beat_t                    fresh_beats [$];
	beat_t                    pending_beats [$];
	int                       mismatches = 0;
	int                       idle_in_pct = 0;
	int                       stall_pct = 0;
	bit                       hold_go = 1'b0;
	logic                     rx_hold = 1'b0;

	circular_list_key_store dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.key         (key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.key_out     (key_out),
		.last_of_run (last_of_run),
		.entry_count (entry_count)
	);

	always #2 clk = ~clk;

	// list state after reset
	task automatic list_reset();
		for (int i = 0; i < CAPACITY; i++) begin
			node_key[i] = '0;
			node_next[i] = '0;
		end
		vacant = '1;
		tail = '0;
		held = 0;
	endtask

	// apply one operation to the predicted list, results go to fresh_beats
	task automatic list_apply(input cls_pkg::op_t op, input logic signed [KEY_W-1:0] k);
		beat_t            b;
		logic [PTR_W-1:0] slot, prev, pres;
		fresh_beats.delete();
		b.st = cls_pkg::STS_OK;
		b.k = '0;
		b.last = 1'b1;
		b.cnt = '0;
		case (op)
			cls_pkg::OP_INS_FRONT, cls_pkg::OP_INS_END: begin
				b.st = cls_pkg::STS_FULL;
				if (held < CAPACITY) begin
					slot = '0;
					// lowest-numbered free node
					for (int i = CAPACITY - 1; i >= 0; i--)
						if (vacant[i])
							slot = PTR_W'(i);
					vacant[slot] = 1'b0;
					node_key[slot] = k;
					if (held == 0) begin
						node_next[slot] = slot;
						tail = slot;
					end else begin
						node_next[slot] = node_next[tail];
						node_next[tail] = slot;
						if (op == cls_pkg::OP_INS_END)
							tail = slot;
					end
					held++;
					b.st = cls_pkg::STS_OK;
				end
				b.cnt = CNT_W'(held);
				fresh_beats.push_back(b);
			end
			cls_pkg::OP_DELETE: begin
				b.st = cls_pkg::STS_EMPTY;
				if (held > 0) begin
					b.st = cls_pkg::STS_MISSING;
					prev = tail;
					pres = node_next[tail];
					// first match front to back
					for (int i = 0; i < held; i++) begin
						if (node_key[pres] == k) begin
							if (held == 1) begin
								tail = '0;
							end else begin
								node_next[prev] = node_next[pres];
								if (pres == tail)
									tail = prev;
							end
							vacant[pres] = 1'b1;
							held--;
							b.st = cls_pkg::STS_OK;
							break;
						end
						prev = pres;
						pres = node_next[pres];
					end
				end
				b.cnt = CNT_W'(held);
				fresh_beats.push_back(b);
			end
			default: begin
				b.cnt = CNT_W'(held);
				if (held == 0) begin
					b.st = cls_pkg::STS_EMPTY;
					fresh_beats.push_back(b);
				end else begin
					pres = node_next[tail];
					for (int i = 0; i < held; i++) begin
						b.k = node_key[pres];
						b.last = (i == held - 1);
						fresh_beats.push_back(b);
						pres = node_next[pres];
					end
				end
			end
		endcase
	endtask

	// key mix: small pool for duplicates and hits, extremes, full range
	function automatic logic signed [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return KEY_W'($urandom_range(8)) - 4;
		if (r < 55) begin
			case ($urandom_range(3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return '0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	// a key that is held somewhere in the predicted list
	function automatic logic signed [KEY_W-1:0] held_key();
		logic [PTR_W-1:0] p;
		int               n;
		p = node_next[tail];
		n = $urandom_range(held - 1);
		repeat (n)
			p = node_next[p];
		return node_key[p];
	endfunction

	// offer one input beat, wait for acceptance, record what should come back
	task automatic send_beat(input cls_pkg::op_t op, input logic signed [KEY_W-1:0] k,
			input logic typed = 1'b0, input cls_pkg::status_t st = cls_pkg::STS_OK,
			input logic [CNT_W-1:0] cnt = '0);
		beat_t b;
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		list_apply(op, k);
		if (typed) begin
			b.st = st;
			b.k = '0;
			b.last = 1'b1;
			b.cnt = cnt;
			pending_beats.push_back(b);
		end else begin
			foreach (fresh_beats[i])
				pending_beats.push_back(fresh_beats[i]);
		end
	endtask

	task automatic send_insert(input logic signed [KEY_W-1:0] k);
		send_beat($urandom_range(1) ? cls_pkg::OP_INS_END : cls_pkg::OP_INS_FRONT, k);
	endtask

	// result check and receiver stalls
	always @(posedge clk) begin
		beat_t b;
		if (out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected beat: status %0d key %0d last %0b count %0d",
						status, key_out, last_of_run, entry_count);
				mismatches++;
			end else begin
				b = pending_beats.pop_front();
				if (status !== b.st || key_out !== b.k || last_of_run !== b.last ||
						entry_count !== b.cnt) begin
					if (mismatches < 10)
						$display("mismatch: expected %0d/%0d/%0b/%0d got %0d/%0d/%0b/%0d",
							b.st, b.k, b.last, b.cnt,
							status, key_out, last_of_run, entry_count);
					mismatches++;
				end
			end
		end
		out_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		rx_hold <= 1'b0;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// stimulus
	initial begin
		int r;
		list_reset();
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIRECTED[i])
			send_beat(DIRECTED[i].op, DIRECTED[i].k, DIRECTED[i].typed,
				DIRECTED[i].st, DIRECTED[i].cnt);

		// random phases with different idling
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_in_pct = 0;  stall_pct = 0;  end
				1: begin idle_in_pct = 62; stall_pct = 0;  end
				2: begin idle_in_pct = 0;  stall_pct = 62; end
				default: begin idle_in_pct = 35; stall_pct = 35; end
			endcase

			// fill the store, push past full, list it
			if (p % 2 == 0) begin
				while (held < CAPACITY)
					send_insert(pick_key());
				send_insert(pick_key());
				send_insert(pick_key());
				send_beat(cls_pkg::OP_DUMP, $urandom);
			end

			if (p == 0)
				hold_go = 1'b1;

			// mixed traffic
			for (int n = 0; n < MIXED_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < 15)
					send_beat(cls_pkg::OP_DUMP, $urandom);
				else if (r < 50)
					send_beat(cls_pkg::OP_DELETE,
						(held > 0 && $urandom_range(3) != 0) ? held_key() : pick_key());
				else
					send_insert(pick_key());
			end

			// empty the list and poke the empty cases
			if (p % 2 == 1) begin
				while (held > 0) begin
					send_beat(cls_pkg::OP_DELETE, held_key());
					if ($urandom_range(7) == 0)
						send_beat(cls_pkg::OP_DUMP, $urandom);
				end
				send_beat(cls_pkg::OP_DELETE, pick_key());
				send_beat(cls_pkg::OP_DUMP, $urandom);
			end
		end
		in_valid <= 1'b0;

		// drain and settle
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/cls_pkg.sv
hdl/cls_ram.sv
hdl/circular_list_key_store.sv
tb/tb_top.sv
